// ----- hdl/aup_pkg.sv -----
`default_nettype none

package aup_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned NumW   = 16;
  localparam int unsigned RecipW = 17;
  localparam int unsigned RecipK = 16;
  localparam int unsigned Depth  = 5;

  typedef struct packed {
    logic          row_last;
    logic [ChW-1:0] alpha_in;
    logic [ChW-1:0] chan_hi;
    logic [ChW-1:0] chan_mid;
    logic [ChW-1:0] chan_lo;
  } pixel_t;

  typedef struct packed {
    logic          row_last_out;
    logic [ChW-1:0] alpha_out;
    logic [ChW-1:0] out_hi;
    logic [ChW-1:0] out_mid;
    logic [ChW-1:0] out_lo;
  } result_t;

  typedef logic [RecipW-1:0] recip_tbl_t [2**ChW];

  function automatic recip_tbl_t build_recip_tbl();
    recip_tbl_t        tbl;
    logic [RecipW:0]   rem;
    logic [RecipW-1:0] quo;
    logic [RecipW-1:0] dividend;
    tbl[0] = '0;
    dividend = RecipW'(1) << RecipK;
    for (int a = 1; a < 2**ChW; a++) begin
      rem = '0;
      quo = '0;
      for (int i = RecipW - 1; i >= 0; i--) begin
        rem = {rem[RecipW-1:0], dividend[i]};
        if (rem >= (RecipW+1)'(a)) begin
          rem = rem - (RecipW+1)'(a);
          quo[i] = 1'b1;
        end
      end
      tbl[a] = quo;
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RecipTbl = build_recip_tbl();

endpackage

`default_nettype wire

// ----- hdl/aup_lane.sv -----
`default_nettype none

module aup_lane
  import aup_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [ChW-1:0]    chan_i,
  input  wire logic [ChW-1:0]    alpha_i,
  input  wire logic [RecipW-1:0] recip_i,
  output logic      [ChW-1:0]    chan_o
);

  logic [NumW-1:0]     num1_q, num1_d;
  logic [ChW-1:0]      alpha1_q;
  logic [RecipW-1:0]   recip1_q;

  logic [NumW+RecipW-1:0] prod2;
  logic [NumW-1:0]     quo2_q, num2_q;
  logic [ChW-1:0]      alpha2_q;

  logic [NumW-1:0]     back3;
  logic [NumW-1:0]     diff3;
  logic [ChW:0]        rem3_q;
  logic [NumW-1:0]     quo3_q;
  logic [ChW-1:0]      alpha3_q;

  logic [NumW:0]       quo4;
  logic [ChW-1:0]      chan_d, chan_q;

  // c*255 + alpha/2
  assign num1_d = ({chan_i, {ChW{1'b0}}} - NumW'(chan_i)) + NumW'(alpha_i[ChW-1:1]);

  always_ff @(posedge clk_i) begin
    num1_q   <= num1_d;
    alpha1_q <= alpha_i;
    recip1_q <= recip_i;
  end

  assign prod2 = NumW'(num1_q) * RecipW'(recip1_q);

  always_ff @(posedge clk_i) begin
    quo2_q   <= prod2[RecipK +: NumW];
    num2_q   <= num1_q;
    alpha2_q <= alpha1_q;
  end

  assign back3 = NumW'(quo2_q * NumW'(alpha2_q));
  assign diff3 = num2_q - back3;

  always_ff @(posedge clk_i) begin
    rem3_q   <= diff3[ChW:0];
    quo3_q   <= quo2_q;
    alpha3_q <= alpha2_q;
  end

  // bump the estimate by one when the remainder still holds a full alpha
  assign quo4 = {1'b0, quo3_q} + (NumW+1)'(rem3_q >= {1'b0, alpha3_q});

  always_comb begin
    if (quo4 > (NumW+1)'({ChW{1'b1}})) begin
      chan_d = {ChW{1'b1}};
    end else begin
      chan_d = quo4[ChW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

// ----- hdl/alpha_unpremultiply_pixel.sv -----
// Alpha un-premultiply for one RGBA8 pixel word.
// Input: drive pixel_i and raise start; the word is taken at a rising edge
// where start is high and busy is low. busy is always low, so one word can
// enter every clock cycle.
// Output: result_o is valid for exactly one cycle while out_valid_o is high.
// The receiver cannot hold results off; words leave in the order they came.
// Stages from the accepting edge to the result register: reciprocal lookup,
// then four lane stages, then zero-alpha select.
// Throughput: one pixel per clock, set by the fully pipelined divide lanes.
// Each colour lane divides by alpha as a multiply by a table reciprocal,
// a back-multiply, and a one-step remainder correction.
// Colours above alpha saturate at 255. Zero alpha gives all-zero bytes;
// the row-end mark always follows its pixel.
// Reset clears every valid bit; words in flight are dropped.
`default_nettype none

module alpha_unpremultiply_pixel
  import aup_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  output logic        busy,
  input  wire pixel_t pixel_i,
  output logic        out_valid_o,
  output result_t     result_o
);

  pixel_t            pix_q;
  logic [RecipW-1:0] recip_q;
  logic [Depth-1:0]  valid_q, valid_d;
  logic [ChW-1:0]    alpha_q [Depth];
  logic              last_q  [Depth];
  logic [ChW-1:0]    lo_w, mid_w, hi_w;
  result_t           res_d, res_q;
  logic              res_valid_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i) begin
    pix_q   <= pixel_i;
    recip_q <= RecipTbl[pixel_i.alpha_in];
  end

  assign valid_d = {valid_q[Depth-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      res_valid_q <= valid_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q[0] <= pixel_i.alpha_in;
    last_q[0]  <= pixel_i.row_last;
    for (int i = 1; i < Depth; i++) begin
      alpha_q[i] <= alpha_q[i-1];
      last_q[i]  <= last_q[i-1];
    end
  end

  aup_lane u_lane_lo (
    .clk_i   (clk_i),
    .chan_i  (pix_q.chan_lo),
    .alpha_i (pix_q.alpha_in),
    .recip_i (recip_q),
    .chan_o  (lo_w)
  );

  aup_lane u_lane_mid (
    .clk_i   (clk_i),
    .chan_i  (pix_q.chan_mid),
    .alpha_i (pix_q.alpha_in),
    .recip_i (recip_q),
    .chan_o  (mid_w)
  );

  aup_lane u_lane_hi (
    .clk_i   (clk_i),
    .chan_i  (pix_q.chan_hi),
    .alpha_i (pix_q.alpha_in),
    .recip_i (recip_q),
    .chan_o  (hi_w)
  );

  always_comb begin
    res_d.row_last_out = last_q[Depth-1];
    res_d.alpha_out    = alpha_q[Depth-1];
    if (alpha_q[Depth-1] == '0) begin
      res_d.out_lo  = '0;
      res_d.out_mid = '0;
      res_d.out_hi  = '0;
    end else begin
      res_d.out_lo  = lo_w;
      res_d.out_mid = mid_w;
      res_d.out_hi  = hi_w;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = res_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// ----- dv/alpha_unpremultiply_checker.sv -----
module alpha_unpremultiply_checker
  import aup_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  input  wire logic    busy,
  input  wire pixel_t  pixel_i,
  input  wire logic    out_valid_o,
  input  wire result_t result_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0] FullScale = 17'd255;

  result_t expected_words[$];

  function automatic logic [ChW-1:0] unpremultiply_lane(logic [ChW-1:0] c,
                                                        logic [ChW-1:0] a);
    logic [16:0] num;
    logic [16:0] quo;
    num = 17'(c) * FullScale + 17'(a >> 1);
    quo = num / 17'(a);
    if (quo > FullScale) begin
      return 8'hff;
    end
    return quo[ChW-1:0];
  endfunction

  function automatic result_t unpremultiply_word(pixel_t p);
    result_t r;
    r.row_last_out = p.row_last;
    if (p.alpha_in == '0) begin
      r.out_lo    = '0;
      r.out_mid   = '0;
      r.out_hi    = '0;
      r.alpha_out = '0;
    end else begin
      r.out_lo    = unpremultiply_lane(p.chan_lo, p.alpha_in);
      r.out_mid   = unpremultiply_lane(p.chan_mid, p.alpha_in);
      r.out_hi    = unpremultiply_lane(p.chan_hi, p.alpha_in);
      r.alpha_out = p.alpha_in;
    end
    return r;
  endfunction

  assign pending_o = expected_words.size();

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (out_valid_o === 1'b1) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual lo=%h mid=%h hi=%h a=%h last=%b",
                   $time, result_i.out_lo, result_i.out_mid, result_i.out_hi,
                   result_i.alpha_out, result_i.row_last_out);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_words.pop_front();
          if (result_i.out_lo !== want.out_lo || result_i.out_mid !== want.out_mid ||
              result_i.out_hi !== want.out_hi || result_i.alpha_out !== want.alpha_out ||
              result_i.row_last_out !== want.row_last_out) begin
            $display("%0t: mismatch: expected lo=%h mid=%h hi=%h a=%h last=%b",
                     $time, want.out_lo, want.out_mid, want.out_hi,
                     want.alpha_out, want.row_last_out);
            $display("%0t:           actual   lo=%h mid=%h hi=%h a=%h last=%b",
                     $time, result_i.out_lo, result_i.out_mid, result_i.out_hi,
                     result_i.alpha_out, result_i.row_last_out);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_words.push_back(unpremultiply_word(pixel_i));
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
module tb
  import aup_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 1050;
  localparam int CycleLimit  = 50000;
  localparam int DrainCycles = 20;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  pixel_t  pixel_word;
  logic    out_valid;
  result_t result_word;
  int      fail_count;
  int      pending;
  int      cycle_count = 0;
  bit      gaps_on;

  alpha_unpremultiply_pixel dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel_word),
    .out_valid_o(out_valid),
    .result_o   (result_word)
  );

  alpha_unpremultiply_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_i     (pixel_word),
    .out_valid_o (out_valid),
    .result_i    (result_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic pixel_t make_pixel(logic [7:0] lo, logic [7:0] mid, logic [7:0] hi,
                                        logic [7:0] a, logic last);
    pixel_t p;
    p.chan_lo  = lo;
    p.chan_mid = mid;
    p.chan_hi  = hi;
    p.alpha_in = a;
    p.row_last = last;
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     kind;
    kind       = $urandom_range(0, 9);
    p.row_last = ($urandom_range(0, 7) == 0);
    case (kind)
      0: begin
        p.alpha_in = 8'd0;
        p.chan_lo  = 8'($urandom);
        p.chan_mid = 8'($urandom);
        p.chan_hi  = 8'($urandom);
      end
      1: begin
        p.alpha_in = 8'($urandom);
        p.chan_lo  = 8'($urandom);
        p.chan_mid = 8'($urandom);
        p.chan_hi  = 8'($urandom);
      end
      2: begin
        p.alpha_in = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(1, 3));
        p.chan_lo  = 8'($urandom_range(0, p.alpha_in));
        p.chan_mid = 8'($urandom_range(0, p.alpha_in));
        p.chan_hi  = 8'($urandom_range(0, p.alpha_in));
      end
      default: begin
        p.alpha_in = 8'($urandom_range(1, 255));
        p.chan_lo  = 8'($urandom_range(0, p.alpha_in));
        p.chan_mid = 8'($urandom_range(0, p.alpha_in));
        p.chan_hi  = 8'($urandom_range(0, p.alpha_in));
      end
    endcase
    return p;
  endfunction

  task automatic send_word(pixel_t p);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    pixel_word <= p;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    start      = 1'b0;
    pixel_word = '0;
    rst_ni     = 1'b0;
    gaps_on    = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_word(make_pixel(8'hff, 8'h80, 8'h01, 8'h00, 1'b1));
    send_word(make_pixel(8'hff, 8'hff, 8'hff, 8'h00, 1'b0));
    send_word(make_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b0));
    send_word(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
    send_word(make_pixel(8'h01, 8'h80, 8'hfe, 8'hff, 1'b0));
    send_word(make_pixel(8'h00, 8'h01, 8'hff, 8'h01, 1'b0));
    send_word(make_pixel(8'h01, 8'h02, 8'h00, 8'h02, 1'b1));
    send_word(make_pixel(8'h01, 8'h02, 8'h03, 8'h03, 1'b0));
    send_word(make_pixel(8'h40, 8'h7f, 8'h80, 8'h80, 1'b0));
    send_word(make_pixel(8'h81, 8'hc0, 8'hff, 8'h80, 1'b1));
    send_word(make_pixel(8'h55, 8'haa, 8'h7f, 8'h7f, 1'b0));
    send_word(make_pixel(8'hfe, 8'hfe, 8'h7f, 8'hfe, 1'b0));
    send_word(make_pixel(8'hff, 8'h00, 8'hfe, 8'hfe, 1'b1));
    send_word(make_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
    send_word(make_pixel(8'h41, 8'h50, 8'h3f, 8'h40, 1'b0));
    send_word(make_pixel(8'h03, 8'h05, 8'h07, 8'h07, 1'b1));
    send_word(make_pixel(8'haa, 8'h55, 8'hcc, 8'hcc, 1'b0));
    send_word(make_pixel(8'h0f, 8'hf0, 8'h33, 8'h3c, 1'b0));
    send_word(make_pixel(8'h64, 8'hc8, 8'h32, 8'hc8, 1'b1));

    for (int i = 0; i < RandomWords; i++) begin
      if (i % 50 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      send_word(random_pixel());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- alpha_unpremultiply_pixel.f -----
hdl/aup_pkg.sv
hdl/aup_lane.sv
hdl/alpha_unpremultiply_pixel.sv
dv/alpha_unpremultiply_checker.sv
dv/tb.sv
